>>> rtl/page_table_walker_core_macros.svh
// assertion macros shared by the page table walker checker
`ifndef PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define PAGE_TABLE_WALKER_CORE_MACROS_SVH

// clocked assertion, off while reset is held, fixed message
`define PTW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("page table walker assertion failed");

// clocked assertion with a caller supplied message
`define PTW_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

>>> rtl/ptw_pkg.sv
// shared types, constants and codes of the page table walker
package ptw_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int FAULT_W  = 2;
  localparam int WIDX_W   = 30;  // word index before reduction: byte address >> 2
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // register decode: paddr bit 2 selects the register
  localparam int   REG_IDX_BIT    = 2;
  localparam logic REG_ROOT_ENTRY = 1'b0;

  // entry flag positions
  localparam int F_PRESENT = 0;
  localparam int F_EXEC    = 3;
  localparam int F_LEAF    = 4;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XLATE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_OK     = 2'd0,
    FAULT_ABSENT = 2'd1,
    FAULT_BAD    = 2'd2,
    FAULT_DENIED = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    PHYS_ZERO = 2'd0,
    PHYS_LIN  = 2'd1,
    PHYS_4M   = 2'd2,
    PHYS_4K   = 2'd3
  } phys_src_e;

  typedef enum logic [1:0] {
    IDX_WRITE = 2'd0,
    IDX_L1    = 2'd1,
    IDX_L2    = 2'd2
  } idx_src_e;

  typedef struct packed {
    logic      item_load;
    logic      idx_start;
    idx_src_e  idx_src;
    logic      mem_we;
    logic      mem_re;
    logic      chk_mem;
    logic      res_load;
    fault_e    res_code;
    phys_src_e res_src;
    logic      out_load;
  } ptw_cmd_t;

  typedef struct packed {
    logic present;
    logic leaf;
    logic base_zero;
    logic mid_zero;
    logic perm_ok;
    logic idx_done;
    logic out_free;
  } ptw_status_t;

endpackage

>>> rtl/ptw_in_if.sv
// request channel: table write or translate
interface ptw_in_if import ptw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  word_t             address;
  word_t             write_data;
  logic [KIND_W-1:0] access_kind;

  modport source (output valid, command, address, write_data, access_kind, input ready);
  modport sink   (input valid, command, address, write_data, access_kind, output ready);
endinterface

>>> rtl/ptw_out_if.sv
// response channel: fault code and physical address
interface ptw_out_if import ptw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FAULT_W-1:0] fault_code;
  word_t              phys_addr;

  modport source (output valid, fault_code, phys_addr, input ready);
  modport sink   (input valid, fault_code, phys_addr, output ready);
endinterface

>>> rtl/ptw_ram.sv
// generic single-write, single-read ram with registered read data
module ptw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ptw_datapath.sv
// walker datapath: item registers, index reduction, entry checks, result registers
module ptw_datapath import ptw_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptw_cmd_t                     cmd_i,
  output ptw_status_t                  status_o,
  input  word_t                        root_entry_i,
  input  word_t                        in_address_i,
  input  word_t                        in_write_data_i,
  input  logic [KIND_W-1:0]            in_access_kind_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [FAULT_W-1:0]           out_fault_code_o,
  output word_t                        out_phys_addr_o,
  output logic                         mem_we_o,
  output logic                         mem_re_o,
  output logic [$clog2(MEM_WORDS)-1:0] mem_addr_o,
  output word_t                        mem_wdata_o,
  input  word_t                        mem_rdata_i
);

  localparam int IDX_W = $clog2(MEM_WORDS);
  localparam bit IS_POW2 = (MEM_WORDS == (64'd1 << IDX_W));

  word_t             lin_q;
  word_t             data_q;
  logic [KIND_W-1:0] kind_q;

  fault_e            pend_code_q;
  word_t             pend_phys_q;
  word_t             pend_phys_d;

  logic              out_valid_q;
  fault_e            out_code_q;
  word_t             out_phys_q;

  word_t             entry;
  logic [3:0]        perm_bits;
  logic [WIDX_W-1:0] x_mux;
  logic [IDX_W-1:0]  idx_q;
  logic              idx_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      lin_q  <= in_address_i;
      data_q <= in_write_data_i;
      kind_q <= in_access_kind_i;
    end
  end

  // entry under test: root register or the word just read from memory
  assign entry     = cmd_i.chk_mem ? mem_rdata_i : root_entry_i;
  assign perm_bits = root_entry_i[F_EXEC:F_PRESENT];

  assign status_o.present   = entry[F_PRESENT];
  assign status_o.leaf      = entry[F_LEAF];
  assign status_o.base_zero = (entry[31:12] == '0);
  assign status_o.mid_zero  = (entry[21:12] == '0);
  assign status_o.perm_ok   = (kind_q != KIND_NONE) && perm_bits[kind_q];
  assign status_o.idx_done  = idx_done_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // unreduced word index of the next memory access
  always_comb begin
    case (cmd_i.idx_src)
      IDX_L1:  x_mux = {root_entry_i[31:12], lin_q[31:22]};
      IDX_L2:  x_mux = {mem_rdata_i[31:12], lin_q[21:12]};
      default: x_mux = lin_q[31:2];
    endcase
  end

  // word index modulo the memory depth
  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_done_q <= 1'b0;
      end else begin
        idx_done_q <= cmd_i.idx_start;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.idx_start) begin
        idx_q <= x_mux[IDX_W-1:0];
      end
    end
  end else begin : g_recip
    // quotient estimate by reciprocal, low by at most one, then one correction
    localparam int RECIP_W = 32 - IDX_W;
    localparam int Q_W     = 31 - IDX_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << WIDX_W) / MEM_WORDS);
    localparam logic [IDX_W-1:0]   M_C   = IDX_W'(MEM_WORDS);

    logic [WIDX_W-1:0]         x_q;
    logic [WIDX_W+RECIP_W-1:0] prod;
    logic [Q_W-1:0]            q_q;
    logic [Q_W+IDX_W-1:0]      qm;
    logic [WIDX_W-1:0]         diff;
    logic [IDX_W:0]            r_q;
    logic [IDX_W:0]            r_sub;
    logic [2:0]                stg_q;

    assign prod  = {{RECIP_W{1'b0}}, x_q} * {{WIDX_W{1'b0}}, RECIP};
    assign qm    = {{IDX_W{1'b0}}, q_q} * {{Q_W{1'b0}}, M_C};
    assign diff  = x_q - qm[WIDX_W-1:0];
    assign r_sub = r_q - {1'b0, M_C};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q      <= '0;
        idx_done_q <= 1'b0;
      end else begin
        stg_q      <= {stg_q[1:0], cmd_i.idx_start};
        idx_done_q <= stg_q[2];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.idx_start) begin
        x_q <= x_mux;
      end
      q_q   <= prod[WIDX_W +: Q_W];
      r_q   <= diff[IDX_W:0];
      idx_q <= (r_q >= {1'b0, M_C}) ? r_sub[IDX_W-1:0] : r_q[IDX_W-1:0];
    end
  end

  assign mem_we_o    = cmd_i.mem_we;
  assign mem_re_o    = cmd_i.mem_re;
  assign mem_addr_o  = idx_q;
  assign mem_wdata_o = data_q;

  always_comb begin
    case (cmd_i.res_src)
      PHYS_LIN: pend_phys_d = lin_q;
      PHYS_4M:  pend_phys_d = {mem_rdata_i[31:22], lin_q[21:0]};
      PHYS_4K:  pend_phys_d = {mem_rdata_i[31:12], lin_q[11:0]};
      default:  pend_phys_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      pend_code_q <= cmd_i.res_code;
      pend_phys_q <= pend_phys_d;
    end
    if (cmd_i.out_load) begin
      out_code_q <= pend_code_q;
      out_phys_q <= pend_phys_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_fault_code_o = out_code_q;
  assign out_phys_addr_o  = out_phys_q;

endmodule

>>> rtl/ptw_ctrl.sv
// walker controller: sequences table writes and the walk levels
module ptw_ctrl import ptw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_command_i,
  output logic        in_ready_o,
  input  ptw_status_t status_i,
  output ptw_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WSTART = 4'd1;
  localparam logic [3:0] S_WWAIT  = 4'd2;
  localparam logic [3:0] S_ROOT   = 4'd3;
  localparam logic [3:0] S_L1WAIT = 4'd4;
  localparam logic [3:0] S_L1CHK  = 4'd5;
  localparam logic [3:0] S_L2WAIT = 4'd6;
  localparam logic [3:0] S_L2CHK  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = (in_command_i == CMD_XLATE) ? S_ROOT : S_WSTART;
        end
      end
      S_WSTART: begin
        cmd_o.idx_start = 1'b1;
        cmd_o.idx_src   = IDX_WRITE;
        state_d         = S_WWAIT;
      end
      S_WWAIT: begin
        if (status_i.idx_done) begin
          cmd_o.mem_we = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_ROOT: begin
        if (!status_i.present) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = FAULT_ABSENT;
          cmd_o.res_src  = PHYS_ZERO;
          state_d        = S_DONE;
        end else if (status_i.leaf) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = PHYS_ZERO;
          if (!status_i.base_zero) begin
            cmd_o.res_code = FAULT_BAD;
          end else if (!status_i.perm_ok) begin
            cmd_o.res_code = FAULT_DENIED;
          end else begin
            cmd_o.res_code = FAULT_OK;
            cmd_o.res_src  = PHYS_LIN;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.idx_start = 1'b1;
          cmd_o.idx_src   = IDX_L1;
          state_d         = S_L1WAIT;
        end
      end
      S_L1WAIT: begin
        if (status_i.idx_done) begin
          cmd_o.mem_re = 1'b1;
          state_d      = S_L1CHK;
        end
      end
      S_L1CHK: begin
        cmd_o.chk_mem = 1'b1;
        if (!status_i.present) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = FAULT_ABSENT;
          cmd_o.res_src  = PHYS_ZERO;
          state_d        = S_DONE;
        end else if (status_i.leaf) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_src  = PHYS_ZERO;
          if (!status_i.mid_zero) begin
            cmd_o.res_code = FAULT_BAD;
          end else if (!status_i.perm_ok) begin
            cmd_o.res_code = FAULT_DENIED;
          end else begin
            cmd_o.res_code = FAULT_OK;
            cmd_o.res_src  = PHYS_4M;
          end
          state_d = S_DONE;
        end else begin
          cmd_o.idx_start = 1'b1;
          cmd_o.idx_src   = IDX_L2;
          state_d         = S_L2WAIT;
        end
      end
      S_L2WAIT: begin
        if (status_i.idx_done) begin
          cmd_o.mem_re = 1'b1;
          state_d      = S_L2CHK;
        end
      end
      S_L2CHK: begin
        cmd_o.chk_mem  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = PHYS_ZERO;
        if (!status_i.present) begin
          cmd_o.res_code = FAULT_ABSENT;
        end else if (!status_i.leaf) begin
          cmd_o.res_code = FAULT_BAD;
        end else if (!status_i.perm_ok) begin
          cmd_o.res_code = FAULT_DENIED;
        end else begin
          cmd_o.res_code = FAULT_OK;
          cmd_o.res_src  = PHYS_4K;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/page_table_walker_core.sv
// page table walker top level: root register port, controller, datapath, table ram
// a translate ends at a 4 GiB root, 4 MiB or 4 KiB leaf, one item at a time; each
// table level costs an index reduction (a masked register, or a reciprocal pipeline
// when MEM_WORDS is not a power of two) plus one registered ram read
// results sit in an output register
// reset clears the controller, the output valid and root_entry; the table ram is not
// cleared and each word is undefined until written
module page_table_walker_core import ptw_pkg::*; #(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ptw_in_if.sink               in_i,
  ptw_out_if.source            out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  localparam int IDX_W = $clog2(MEM_WORDS);

  word_t            root_q;
  logic             cfg_wr;
  ptw_cmd_t         cmd;
  ptw_status_t      status;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_addr;
  word_t            mem_wdata;
  word_t            mem_rdata;

  // register port: zero wait states, write lands on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && (paddr[REG_IDX_BIT] == REG_ROOT_ENTRY)) begin
      root_q <= pwdata;
    end
  end

  assign prdata = (paddr[REG_IDX_BIT] == REG_ROOT_ENTRY) ? root_q : '0;

  // sequencing: one transfer in, walk levels, one transfer out per translate
  ptw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // entry checks, index reduction and result registers
  ptw_datapath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .root_entry_i     (root_q),
    .in_address_i     (in_i.address),
    .in_write_data_i  (in_i.write_data),
    .in_access_kind_i (in_i.access_kind),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_fault_code_o (out_o.fault_code),
    .out_phys_addr_o  (out_o.phys_addr),
    .mem_we_o         (mem_we),
    .mem_re_o         (mem_re),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata)
  );

  // table words, one port each for write and read, same index source
  ptw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_WORDS)
  ) u_table_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule

>>> rtl/ptw_checker.sv
// port level checks of the page table walker, bound to the top level
`include "page_table_walker_core_macros.svh"

module ptw_checker import ptw_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FAULT_W-1:0] out_fault_code_i,
  input word_t              out_phys_addr_i,
  input logic               psel_i,
  input logic               pready_i
);

  logic                      in_xfer;
  logic                      out_stall;
  logic                      out_faulted;
  logic [FAULT_W+DATA_W-1:0] out_payload;

  assign in_xfer     = in_valid_i && in_ready_i;
  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_faulted = out_valid_i && (out_fault_code_i != FAULT_OK);
  assign out_payload = {out_fault_code_i, out_phys_addr_i};

  // a stalled result keeps its payload
  `PTW_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_i && $stable(out_payload))

  // a faulting translate reports address zero
  `PTW_ASSERT(a_fault_phys_zero, clk_i, rst_ni, out_faulted |-> out_phys_addr_i == '0)

  // one item at a time: input closes after a transfer
  `PTW_ASSERT(a_busy_after_in, clk_i, rst_ni, in_xfer |=> !in_ready_i)

  // no result appears in the cycle after a request transfer
  `PTW_ASSERT(a_no_early_result, clk_i, rst_ni, in_xfer |=> !$rose(out_valid_i))

  `PTW_ASSERT_MSG(a_pready_high, clk_i, rst_ni, psel_i |-> pready_i, "register port stalled")

endmodule

bind page_table_walker_core ptw_checker u_ptw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_fault_code_i (out_o.fault_code),
  .out_phys_addr_i  (out_o.phys_addr),
  .psel_i           (psel),
  .pready_i         (pready)
);
